// ----- rtl/ppyg_pkg.sv -----
// Shared types and constants for the peer proximity yield guard.
// No dependencies.
`timescale 1ns / 1ps
package ppyg_pkg;
    localparam int MaxPeers     = 16;
    localparam int SlotW        = (MaxPeers > 1) ? $clog2(MaxPeers) : 1;
    localparam int CntW         = $clog2(MaxPeers + 1);
    localparam int MoveThreshMm = 100;
    localparam int PosW         = 24;
    localparam int TimeW        = 40;
    localparam int DistW        = 50;
    localparam int CfgIdxW      = 3;
    localparam int TrackW       = 8 + 4 * PosW + 2 * TimeW;

    localparam logic [CfgIdxW-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_OWN_ID  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RESUME  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STALE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_RSTALE  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_STATIC  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_KEEP    = 3'd7;

    localparam logic [2:0] NOTE_HOLD   = 3'd0;
    localparam logic [2:0] NOTE_STALE  = 3'd1;
    localparam logic [2:0] NOTE_PARKED = 3'd2;
    localparam logic [2:0] NOTE_CLEAR  = 3'd3;
    localparam logic [2:0] NOTE_NOPEER = 3'd4;

    typedef struct packed {
        logic [7:0]       ident;
        logic [PosW-1:0]  px;
        logic [PosW-1:0]  py;
        logic [PosW-1:0]  ax;
        logic [PosW-1:0]  ay;
        logic [TimeW-1:0] seen;
        logic [TimeW-1:0] moved;
    } t_track;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic clr;       // clear scan accumulators
        logic rd;        // issue read of slot
        logic sq;        // register differences
        logic mul;       // register squares
        logic step;      // fold one entry (pose match or evaluate compare)
        logic write;     // write pose result
        logic finish;    // form the result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_eval;
        logic own_drop;
        logic matched;
        logic have_free;
    } t_sts;
endpackage

// ----- rtl/peer_proximity_yield_guard.sv -----
// Top level of the peer proximity yield guard: controller plus datapath.
// Depends on ppyg_pkg, ppyg_ctrl and ppyg_dp.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------------
//  in      | i_in_valid / o_in_ready      | command, peer_ident, pos_x/y, time, holding
//  out     | o_out_valid / i_out_ready    | hold, peer_valid, nearest_peer, dist, note
//  cfg     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Every item runs from acceptance to the next possible acceptance through 16 table
// reads, one per cycle, a three-stage data / square / fold pipe behind them, a drain of
// that pipe, two closing states and the idle state that takes the next item.
// Evaluate yields one transaction on out; pose updates yield none.
// A new item is taken once the previous result has been consumed.
// Synchronous active-low reset empties the track table and loads register defaults.
`timescale 1ns / 1ps
module peer_proximity_yield_guard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [7:0]         i_peer_ident,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [39:0]        i_time_ms,
    input  logic               i_holding_now,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hold,
    output logic               o_peer_valid,
    output logic [7:0]         o_nearest_peer,
    output logic [49:0]        o_dist_squared,
    output logic [2:0]         o_note,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ppyg_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ppyg_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [SlotW-1:0] slot;

    assign o_cfg_ready = 1'b1;

    ppyg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_slot      (slot)
    );

    ppyg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_slot         (slot),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_peer_ident   (i_peer_ident),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_time_ms      (i_time_ms),
        .i_holding_now  (i_holding_now),
        .o_hold         (o_hold),
        .o_peer_valid   (o_peer_valid),
        .o_nearest_peer (o_nearest_peer),
        .o_dist_squared (o_dist_squared),
        .o_note         (o_note)
    );
endmodule

// ----- rtl/ppyg_ram.sv -----
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ppyg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ppyg_ctrl.sv -----
// Sequencer for the peer proximity yield guard: handshakes and scan order.
// Depends on ppyg_pkg.
`timescale 1ns / 1ps
module ppyg_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  ppyg_pkg::t_sts          i_sts,
    output ppyg_pkg::t_cmd          o_cmd,
    output logic [ppyg_pkg::SlotW-1:0] o_slot
);
    import ppyg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DONE = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // scan pipeline: read issue, then data, square, fold (3 stages behind issue)
    logic [2:0]      r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [2:0]      r_pipe, n_pipe;
    logic            r_out_valid, n_out_valid;
    logic            accept, issue;

    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign issue = (r_state == S_SCAN) && (r_cnt < CntW'(MaxPeers));
    assign o_slot = r_cnt[SlotW-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pipe = {r_pipe[1:0], issue};
        n_out_valid = r_out_valid;
        o_cmd = '0;
        o_cmd.rd = issue;
        o_cmd.sq = r_pipe[0];
        o_cmd.mul = r_pipe[1];
        o_cmd.step = r_pipe[2];
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr = 1'b1;
                    n_cnt = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (r_pipe == 3'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.is_eval) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                o_cmd.write = !i_sts.own_drop && (i_sts.matched || i_sts.have_free);
                n_state = S_IDLE;
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pipe <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pipe <= n_pipe;
            r_out_valid <= n_out_valid;
        end
    end
    assign o_out_valid = r_out_valid;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept) else $error("accept while busy");
    a_pipe_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_pipe == 3'd0)) else $error("scan not drained");
    a_out_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT) else $error("stray result");
endmodule

// ----- rtl/ppyg_dp.sv -----
// Datapath: track table, distance squares, scan accumulators and result.
// Depends on ppyg_pkg and ppyg_ram.
`timescale 1ns / 1ps
module ppyg_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ppyg_pkg::t_cmd             i_cmd,
    input  logic [ppyg_pkg::SlotW-1:0] i_slot,
    output ppyg_pkg::t_sts             o_sts,
    input  logic                       i_cfg_valid,
    input  logic [ppyg_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic                       i_command,
    input  logic [7:0]                 i_peer_ident,
    input  logic signed [23:0]         i_pos_x,
    input  logic signed [23:0]         i_pos_y,
    input  logic [39:0]                i_time_ms,
    input  logic                       i_holding_now,
    output logic                       o_hold,
    output logic                       o_peer_valid,
    output logic [7:0]                 o_nearest_peer,
    output logic [49:0]                o_dist_squared,
    output logic [2:0]                 o_note
);
    import ppyg_pkg::*;

    // configuration
    logic        r_en;
    logic [7:0]  r_own;
    logic [15:0] r_hold_d, r_resume_d, r_stale, r_rstale, r_keep;
    logic [19:0] r_static;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1;
            r_own <= '0;
            r_hold_d <= 16'd1500;
            r_resume_d <= 16'd2000;
            r_stale <= 16'd1000;
            r_rstale <= 16'd3000;
            r_static <= 20'd5000;
            r_keep <= 16'd800;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_en <= i_cfg_data[0];
                CFG_OWN_ID: r_own <= i_cfg_data[7:0];
                CFG_HOLD:   r_hold_d <= i_cfg_data[15:0];
                CFG_RESUME: r_resume_d <= i_cfg_data[15:0];
                CFG_STALE:  r_stale <= i_cfg_data[15:0];
                CFG_RSTALE: r_rstale <= i_cfg_data[15:0];
                CFG_STATIC: r_static <= i_cfg_data[19:0];
                CFG_KEEP:   r_keep <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic        r_cmd;
    logic [7:0]  r_id;
    logic [23:0] r_x, r_y;
    logic [39:0] r_now;
    logic [31:0] r_trig2, r_keep2;
    logic [16:0] r_maxage;
    logic [15:0] trig;

    assign trig = (i_holding_now && (r_resume_d > r_hold_d)) ? r_resume_d : r_hold_d;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_id <= i_peer_ident;
            r_x <= i_pos_x;
            r_y <= i_pos_y;
            r_now <= i_time_ms;
            r_trig2 <= trig * trig;
            r_keep2 <= r_keep * r_keep;
            r_maxage <= {1'b0, i_holding_now ? r_rstale : r_stale};
        end
    end

    // valid bits in flops, payload in RAM
    logic [MaxPeers-1:0] r_valid;
    t_track              rd_trk, wr_trk;
    logic [SlotW-1:0]    wr_slot;

    ppyg_ram #(.Width(TrackW), .Depth(MaxPeers)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (wr_slot),
        .i_wdata (wr_trk),
        .i_raddr (i_slot),
        .o_rdata (rd_trk)
    );

    // stage 1: data arrives (slot delayed), stage 2: diffs, stage 3: squares
    logic [SlotW-1:0] r_s1, r_s2, r_s3, r_s4;
    logic             r_v2, r_v3, r_v4;
    t_track           r_t2, r_t3, r_t4;
    logic [24:0]      r_dx, r_dy, r_mx, r_my;
    logic [49:0]      r_d2, r_m2;
    logic signed [24:0] dx, dy, mx, my;
    logic [24:0]      ax, ay, amx, amy;
    logic             rd_v;

    assign rd_v = r_valid[r_s1];
    // evaluate: track pos vs own pos; pose: new pos vs track anchor
    assign dx = {rd_trk.px[23], rd_trk.px} - {r_x[23], r_x};
    assign dy = {rd_trk.py[23], rd_trk.py} - {r_y[23], r_y};
    assign mx = {r_x[23], r_x} - {rd_trk.ax[23], rd_trk.ax};
    assign my = {r_y[23], r_y} - {rd_trk.ay[23], rd_trk.ay};
    assign ax = dx[24] ? 25'(-dx) : dx;
    assign ay = dy[24] ? 25'(-dy) : dy;
    assign amx = mx[24] ? 25'(-mx) : mx;
    assign amy = my[24] ? 25'(-my) : my;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_s1 <= i_slot;
        end
        if (i_cmd.sq) begin
            r_s2 <= r_s1;
            r_v2 <= rd_v;
            r_t2 <= rd_trk;
            r_dx <= ax;
            r_dy <= ay;
            r_mx <= amx;
            r_my <= amy;
        end
        if (i_cmd.mul) begin
            r_s3 <= r_s2;
            r_v3 <= r_v2;
            r_t3 <= r_t2;
            r_d2 <= 50'(r_dx * r_dx) + 50'(r_dy * r_dy);
            r_m2 <= 50'(r_mx * r_mx) + 50'(r_my * r_my);
        end
    end
    assign r_s4 = r_s3;
    assign r_v4 = r_v3;
    assign r_t4 = r_t3;

    // fold stage
    logic        fresh, parked, trig_hit;
    logic [40:0] age_seen, age_moved;

    assign age_seen = {1'b0, r_now} - {1'b0, r_t4.seen};
    assign age_moved = {1'b0, r_now} - {1'b0, r_t4.moved};
    assign fresh = !age_seen[40] && (age_seen[39:0] <= 40'(r_maxage));
    assign parked = !age_moved[40] && (age_moved[39:0] != '0)
        && (age_moved[39:0] > 40'(r_static)) && (r_d2 >= 50'(r_keep2));
    assign trig_hit = fresh && !parked && (r_d2 < 50'(r_trig2));

    logic        r_hold, r_near, r_match, r_free_ok;
    logic [7:0]  r_hold_id, r_near_id;
    logic [49:0] r_hold_dd, r_near_dd;
    logic [2:0]  r_near_code;
    logic [SlotW-1:0] r_match_slot, r_free_slot;
    t_track      r_match_trk;
    logic        r_moved;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_hold <= 1'b0;
            r_near <= 1'b0;
            r_match <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.step) begin
            if (!r_v4) begin
                if (!r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free_slot <= r_s4;
                end
            end else if (r_cmd) begin
                if (r_t4.ident < r_own) begin
                    if (trig_hit) begin
                        if (!r_hold || r_d2 < r_hold_dd) begin
                            r_hold <= 1'b1;
                            r_hold_dd <= r_d2;
                            r_hold_id <= r_t4.ident;
                        end
                    end else if (!r_near || r_d2 < r_near_dd) begin
                        r_near <= 1'b1;
                        r_near_dd <= r_d2;
                        r_near_id <= r_t4.ident;
                        r_near_code <= !fresh ? NOTE_STALE :
                                       (parked ? NOTE_PARKED : NOTE_CLEAR);
                    end
                end
            end else if (!r_match && r_t4.ident == r_id) begin
                r_match <= 1'b1;
                r_match_slot <= r_s4;
                r_match_trk <= r_t4;
                r_moved <= r_m2 > 50'(MoveThreshMm * MoveThreshMm);
            end
        end
    end

    // pose write
    always_comb begin
        wr_trk.ident = r_id;
        wr_trk.px = r_x;
        wr_trk.py = r_y;
        wr_trk.seen = r_now;
        if (r_match && !r_moved) begin
            wr_trk.ax = r_match_trk.ax;
            wr_trk.ay = r_match_trk.ay;
            wr_trk.moved = r_match_trk.moved;
        end else begin
            wr_trk.ax = r_x;
            wr_trk.ay = r_y;
            wr_trk.moved = r_now;
        end
    end
    assign wr_slot = r_match ? r_match_slot : r_free_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write) begin
            r_valid[wr_slot] <= 1'b1;
        end
    end

    assign o_sts.is_eval = r_cmd;
    assign o_sts.own_drop = (r_id == r_own);
    assign o_sts.matched = r_match;
    assign o_sts.have_free = r_free_ok;

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (!r_en) begin
                o_hold <= 1'b0;
                o_peer_valid <= 1'b0;
                o_nearest_peer <= '0;
                o_dist_squared <= '0;
                o_note <= NOTE_HOLD;
            end else if (r_hold) begin
                o_hold <= 1'b1;
                o_peer_valid <= 1'b1;
                o_nearest_peer <= r_hold_id;
                o_dist_squared <= r_hold_dd;
                o_note <= NOTE_HOLD;
            end else if (r_near) begin
                o_hold <= 1'b0;
                o_peer_valid <= 1'b1;
                o_nearest_peer <= r_near_id;
                o_dist_squared <= r_near_dd;
                o_note <= r_near_code;
            end else begin
                o_hold <= 1'b0;
                o_peer_valid <= 1'b0;
                o_nearest_peer <= '0;
                o_dist_squared <= '0;
                o_note <= NOTE_NOPEER;
            end
        end
    end

    a_write_pose_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> !r_cmd) else $error("table write during evaluate");
    a_no_own_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (r_id != r_own)) else $error("own id written");
    a_new_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write && !r_match) |-> !r_valid[r_free_slot]) else $error("slot overwritten");
endmodule
